/* rtl/pnt_pkg.sv */
package pnt_pkg;

  // Field widths fixed by the interface
  localparam int COORD_W     = 24;
  localparam int TURB_W      = 24;
  localparam int OCT_CFG_W   = 4;
  localparam int FREQ_W      = 16;
  localparam int AMP_STEP_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Defaults for the top level parameters
  localparam int MAX_OCTAVES_DEF   = 8;
  localparam int FRACTION_BITS_DEF = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE_STEP = 2'd2;

  // Configuration reset values
  localparam logic [OCT_CFG_W-1:0]         OCT_RESET  = 4'd1;
  localparam logic [FREQ_W-1:0]            FREQ_RESET = 16'd8192;
  localparam logic signed [AMP_STEP_W-1:0] AMP_RESET  = 16'sd8192;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } pnt_in_t;

  typedef struct packed {
    logic [TURB_W-1:0] turbulence_value;
    logic              saturated;
  } pnt_out_t;

  // Top level to sequencer
  typedef struct packed {
    logic start;
    logic fin_ack;
  } pnt_ctl_t;

  // Sequencer to top level
  typedef struct packed {
    logic idle;
    logic fin;
  } pnt_stat_t;

  // Reference permutation of the noise hash
  localparam logic [7:0] PERM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  function automatic logic [7:0] pnt_perm(input logic [7:0] idx);
    return PERM[idx];
  endfunction

endpackage

/* rtl/perlin_noise_turbulence_3d_unit.sv */
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_data   (coord_x, coord_y, coord_z)
// out      out_valid / out_ready  out_data  (turbulence_value, saturated)
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each item runs N octaves, N = min(octave_count, MAX_OCTAVES), each on the
// single shared multiplier: 30 multiplies and 14 hash table reads a octave.
// Zero octaves go straight to finish. in_ready is high only while the sequencer is idle.
// A finished result sits in the output register; the sequencer holds until it is free.
// Reset is synchronous, active low; cfg writes are always taken.
module perlin_noise_turbulence_3d_unit #(
  parameter int MAX_OCTAVES   = pnt_pkg::MAX_OCTAVES_DEF,
  parameter int FRACTION_BITS = pnt_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pnt_pkg::pnt_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pnt_pkg::pnt_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pnt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pnt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pnt_pkg::*;

  logic [OCT_CFG_W-1:0]         octave_count_r;
  logic [FREQ_W-1:0]            frequency_step_r;
  logic signed [AMP_STEP_W-1:0] amplitude_step_r;
  logic                         out_valid_r;
  pnt_out_t                     out_data_r;
  pnt_ctl_t                     ctl;
  pnt_stat_t                    stat;
  pnt_out_t                     result;
  logic                         load;

  pnt_seq #(
    .MAX_OCTAVES   (MAX_OCTAVES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .in_item        (in_data),
    .octave_count   (octave_count_r),
    .frequency_step (frequency_step_r),
    .amplitude_step (amplitude_step_r),
    .stat           (stat),
    .result         (result)
  );

  assign in_ready    = stat.idle;
  assign cfg_ready   = 1'b1;
  assign load        = stat.fin && (!out_valid_r || out_ready);
  assign ctl.start   = in_valid && in_ready;
  assign ctl.fin_ack = load;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r   <= OCT_RESET;
      frequency_step_r <= FREQ_RESET;
      amplitude_step_r <= AMP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OCTAVE_COUNT:   octave_count_r   <= cfg_data[OCT_CFG_W-1:0];
        CFG_FREQUENCY_STEP: frequency_step_r <= cfg_data;
        CFG_AMPLITUDE_STEP: amplitude_step_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Hold the finished item until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (load)
      out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/pnt_mul.sv */
module pnt_mul #(
  parameter int MUL_W = 25
) (
  input  logic                      clk,
  input  logic signed [MUL_W-1:0]   mul_a,
  input  logic signed [MUL_W-1:0]   mul_b,
  output logic signed [2*MUL_W-1:0] mul_p_r
);

  // Register the product of the shared multiplier
  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

endmodule

/* rtl/pnt_seq.sv */
module pnt_seq #(
  parameter int MAX_OCTAVES   = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  pnt_pkg::pnt_ctl_t                      ctl,
  input  pnt_pkg::pnt_in_t                       in_item,
  input  logic [pnt_pkg::OCT_CFG_W-1:0]          octave_count,
  input  logic [pnt_pkg::FREQ_W-1:0]             frequency_step,
  input  logic signed [pnt_pkg::AMP_STEP_W-1:0]  amplitude_step,
  output pnt_pkg::pnt_stat_t                     stat,
  output pnt_pkg::pnt_out_t                      result
);
  import pnt_pkg::*;

  localparam int F      = FRACTION_BITS;
  localparam int AMP_W  = 16 + MAX_OCTAVES;
  localparam int MW0    = (F + 5 > 25) ? F + 5 : 25;
  localparam int MUL_W  = (AMP_W > MW0) ? AMP_W : MW0;
  localparam int P_W    = 2 * MUL_W;
  localparam int V_W    = F + 3;
  localparam int SUM_W  = (20 + MAX_OCTAVES + F > 40) ? 20 + MAX_OCTAVES + F : 40;
  localparam int Q_W    = SUM_W - 14;
  localparam int OCT_CW = $clog2(MAX_OCTAVES + 1);
  localparam int SCL_W  = 48;
  localparam int ACC_W  = 64;

  localparam logic [SCL_W-1:0]        SCALE_CAP   = '1;
  localparam logic [SCL_W-1:0]        SCALE_ONE   = SCL_W'(4096);
  localparam logic signed [AMP_W-1:0] AMP_ONE     = AMP_W'(16384);
  localparam logic [F+4:0]            FIFTEEN_ONE = (F+5)'(15) << F;
  localparam logic signed [F+4:0]     TEN_ONE     = (F+5)'(10) << F;
  localparam logic signed [F+1:0]     ONE_C       = (F+2)'(1) << F;
  localparam logic signed [V_W:0]     ONE_N       = (V_W+1)'(1) << F;

  // Step codes of one octave
  localparam logic [5:0] ST_SX0 = 6'd0,  ST_SX1 = 6'd1,  ST_SY0 = 6'd2,  ST_SY1 = 6'd3;
  localparam logic [5:0] ST_SZ0 = 6'd4,  ST_SZ1 = 6'd5;
  localparam logic [5:0] ST_HA  = 6'd6,  ST_HB  = 6'd7,  ST_HAA = 6'd8,  ST_HAB = 6'd9;
  localparam logic [5:0] ST_HBA = 6'd10, ST_HBB = 6'd11;
  localparam logic [5:0] ST_G0  = 6'd12, ST_G1  = 6'd13, ST_G2  = 6'd14, ST_G3  = 6'd15;
  localparam logic [5:0] ST_G4  = 6'd16, ST_G5  = 6'd17, ST_G6  = 6'd18, ST_G7  = 6'd19;
  localparam logic [5:0] ST_FXA = 6'd20, ST_FXB = 6'd21, ST_FXC = 6'd22, ST_FXD = 6'd23;
  localparam logic [5:0] ST_FYA = 6'd24, ST_FYB = 6'd25, ST_FYC = 6'd26, ST_FYD = 6'd27;
  localparam logic [5:0] ST_FZA = 6'd28, ST_FZB = 6'd29, ST_FZC = 6'd30, ST_FZD = 6'd31;
  localparam logic [5:0] ST_L0  = 6'd32, ST_L1  = 6'd33, ST_LO  = 6'd34, ST_L2  = 6'd35;
  localparam logic [5:0] ST_L3  = 6'd36, ST_HI  = 6'd37, ST_LR  = 6'd38, ST_ACC = 6'd39;
  localparam logic [5:0] ST_AMP = 6'd40, ST_SC0 = 6'd41, ST_SC1 = 6'd42, ST_SC2 = 6'd43;
  localparam logic [5:0] ST_CAP = 6'd44;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_t;

  state_t                    state_r, state_nxt;
  logic [5:0]                step_r, step_nxt;
  logic                      phase_r, phase_nxt;
  logic [OCT_CW-1:0]         oct_r, oct_nxt, n_r, n_nxt;
  logic [COORD_W-1:0]        cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [COORD_W-1:0]        sx_r, sx_nxt, sy_r, sy_nxt, sz_r, sz_nxt;
  logic [35:0]               tmp_r, tmp_nxt, s36;
  logic [SCL_W-1:0]          scale_r, scale_nxt;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic signed [AMP_W-1:0]   amp_r, amp_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic [7:0]                a_r, a_nxt, b_r, b_nxt;
  logic [7:0]                aa_r, aa_nxt, ab_r, ab_nxt, ba_r, ba_nxt, bb_r, bb_nxt;
  logic [3:0]                hh_r [8];
  logic [3:0]                hh_nxt [8];
  logic signed [F+4:0]       inner_r, inner_nxt;
  logic [F-1:0]              t2_r, t2_nxt, t3_r, t3_nxt;
  logic [F:0]                u_r, u_nxt, v_r, v_nxt, w_r, w_nxt;
  logic signed [V_W-1:0]     l0_r, l0_nxt, l1_r, l1_nxt, l2_r, l2_nxt, l3_r, l3_nxt;
  logic signed [V_W-1:0]     lo_r, lo_nxt, hi_r, hi_nxt, res_r, res_nxt;

  logic                      is_rom, is_mul;
  logic [31:0]               sxw, syw, szw;
  logic [7:0]                cell_x, cell_y, cell_z;
  logic [F-1:0]              xf, yf, zf, t_sel;
  logic signed [F+1:0]       x0, x1, y0, y1, z0, z1;
  logic [F+4:0]              a6;
  logic signed [V_W-1:0]     g [8];
  logic signed [V_W-1:0]     la, lb;
  logic signed [V_W:0]       ldiff;
  logic [F:0]                lt;
  logic signed [V_W:0]       nsum;
  logic signed [V_W-1:0]     noise;
  logic [7:0]                rom_idx, rom_q;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [P_W-1:0]     mul_p;
  logic [SUM_W-1:0]          sum_abs;
  logic [Q_W-1:0]            q;

  function automatic logic signed [V_W-1:0] grad_f(input logic [3:0] h,
                                                   input logic signed [F+1:0] gx,
                                                   input logic signed [F+1:0] gy,
                                                   input logic signed [F+1:0] gz);
    logic signed [V_W-1:0] gu, gv;
    gu = (h < 4'd8) ? V_W'(gx) : V_W'(gy);
    if (h < 4'd4)
      gv = V_W'(gy);
    else if (h == 4'd12 || h == 4'd14)
      gv = V_W'(gx);
    else
      gv = V_W'(gz);
    if (h[0]) gu = -gu;
    if (h[1]) gv = -gv;
    return gu + gv;
  endfunction

  pnt_mul #(.MUL_W(MUL_W)) u_mul (
    .clk     (clk),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .mul_p_r (mul_p)
  );

  // Split scaled coordinates into cell and fraction
  assign sxw    = 32'(sx_r) >> F;
  assign syw    = 32'(sy_r) >> F;
  assign szw    = 32'(sz_r) >> F;
  assign cell_x = sxw[7:0];
  assign cell_y = syw[7:0];
  assign cell_z = szw[7:0];
  assign xf     = sx_r[F-1:0];
  assign yf     = sy_r[F-1:0];
  assign zf     = sz_r[F-1:0];
  assign x0     = $signed({2'b00, xf});
  assign y0     = $signed({2'b00, yf});
  assign z0     = $signed({2'b00, zf});
  assign x1     = x0 - ONE_C;
  assign y1     = y0 - ONE_C;
  assign z1     = z0 - ONE_C;

  // Corner gradients
  assign g[0] = grad_f(hh_r[0], x0, y0, z0);
  assign g[1] = grad_f(hh_r[1], x1, y0, z0);
  assign g[2] = grad_f(hh_r[2], x0, y1, z0);
  assign g[3] = grad_f(hh_r[3], x1, y1, z0);
  assign g[4] = grad_f(hh_r[4], x0, y0, z1);
  assign g[5] = grad_f(hh_r[5], x1, y0, z1);
  assign g[6] = grad_f(hh_r[6], x0, y1, z1);
  assign g[7] = grad_f(hh_r[7], x1, y1, z1);

  assign is_rom = (step_r >= ST_HA) && (step_r <= ST_G7);
  assign is_mul = !is_rom && (step_r != ST_CAP);

  // Select fade input and lerp operands
  always_comb begin
    case (step_r)
      ST_FYA, ST_FYB, ST_FYC, ST_FYD: t_sel = yf;
      ST_FZA, ST_FZB, ST_FZC, ST_FZD: t_sel = zf;
      default:                        t_sel = xf;
    endcase
    case (step_r)
      ST_L0:   begin lt = u_r; la = g[0]; lb = g[1]; end
      ST_L1:   begin lt = u_r; la = g[2]; lb = g[3]; end
      ST_LO:   begin lt = v_r; la = l0_r; lb = l1_r; end
      ST_L2:   begin lt = u_r; la = g[4]; lb = g[5]; end
      ST_L3:   begin lt = u_r; la = g[6]; lb = g[7]; end
      ST_HI:   begin lt = v_r; la = l2_r; lb = l3_r; end
      default: begin lt = w_r; la = lo_r; lb = hi_r; end
    endcase
  end

  assign a6    = ({5'b0, t_sel} << 2) + ({5'b0, t_sel} << 1) - FIFTEEN_ONE;
  assign ldiff = (V_W+1)'(lb) - (V_W+1)'(la);
  assign nsum  = (V_W+1)'(res_r) + ONE_N;
  assign noise = nsum[V_W:1];
  assign s36   = tmp_r + {mul_p[17:0], 18'b0};

  // Hash table address
  always_comb begin
    case (step_r)
      ST_HA:   rom_idx = cell_x;
      ST_HB:   rom_idx = cell_x + 8'd1;
      ST_HAA:  rom_idx = a_r;
      ST_HAB:  rom_idx = a_r + 8'd1;
      ST_HBA:  rom_idx = b_r;
      ST_HBB:  rom_idx = b_r + 8'd1;
      ST_G0:   rom_idx = aa_r;
      ST_G1:   rom_idx = ba_r;
      ST_G2:   rom_idx = ab_r;
      ST_G3:   rom_idx = bb_r;
      ST_G4:   rom_idx = aa_r + 8'd1;
      ST_G5:   rom_idx = ba_r + 8'd1;
      ST_G6:   rom_idx = ab_r + 8'd1;
      ST_G7:   rom_idx = bb_r + 8'd1;
      default: rom_idx = 8'd0;
    endcase
  end
  assign rom_q = pnt_perm(rom_idx);

  // Multiplier operands
  always_comb begin
    case (step_r)
      ST_SX0: begin mul_a = MUL_W'($signed(cx_r)); mul_b = MUL_W'(scale_r[17:0]);  end
      ST_SX1: begin mul_a = MUL_W'($signed(cx_r)); mul_b = MUL_W'(scale_r[35:18]); end
      ST_SY0: begin mul_a = MUL_W'($signed(cy_r)); mul_b = MUL_W'(scale_r[17:0]);  end
      ST_SY1: begin mul_a = MUL_W'($signed(cy_r)); mul_b = MUL_W'(scale_r[35:18]); end
      ST_SZ0: begin mul_a = MUL_W'($signed(cz_r)); mul_b = MUL_W'(scale_r[17:0]);  end
      ST_SZ1: begin mul_a = MUL_W'($signed(cz_r)); mul_b = MUL_W'(scale_r[35:18]); end
      ST_FXA, ST_FYA, ST_FZA: begin
        mul_a = MUL_W'(t_sel);
        mul_b = MUL_W'($signed(a6));
      end
      ST_FXB, ST_FYB, ST_FZB: begin mul_a = MUL_W'(t_sel); mul_b = MUL_W'(t_sel); end
      ST_FXC, ST_FYC, ST_FZC: begin mul_a = MUL_W'(t2_r);  mul_b = MUL_W'(t_sel); end
      ST_FXD, ST_FYD, ST_FZD: begin mul_a = MUL_W'(t3_r);  mul_b = MUL_W'(inner_r); end
      ST_L0, ST_L1, ST_LO, ST_L2, ST_L3, ST_HI, ST_LR: begin
        mul_a = MUL_W'(lt);
        mul_b = MUL_W'(ldiff);
      end
      ST_ACC: begin mul_a = MUL_W'(amp_r); mul_b = MUL_W'(noise); end
      ST_AMP: begin mul_a = MUL_W'(amp_r); mul_b = MUL_W'(amplitude_step); end
      ST_SC0: begin mul_a = MUL_W'(scale_r[15:0]);  mul_b = MUL_W'(frequency_step); end
      ST_SC1: begin mul_a = MUL_W'(scale_r[31:16]); mul_b = MUL_W'(frequency_step); end
      ST_SC2: begin mul_a = MUL_W'(scale_r[47:32]); mul_b = MUL_W'(frequency_step); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Sequencer and write-back
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    phase_nxt = phase_r;
    oct_nxt   = oct_r;
    n_nxt     = n_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    cz_nxt    = cz_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    sz_nxt    = sz_r;
    tmp_nxt   = tmp_r;
    scale_nxt = scale_r;
    acc_nxt   = acc_r;
    amp_nxt   = amp_r;
    sum_nxt   = sum_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    aa_nxt    = aa_r;
    ab_nxt    = ab_r;
    ba_nxt    = ba_r;
    bb_nxt    = bb_r;
    hh_nxt    = hh_r;
    inner_nxt = inner_r;
    t2_nxt    = t2_r;
    t3_nxt    = t3_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    w_nxt     = w_r;
    l0_nxt    = l0_r;
    l1_nxt    = l1_r;
    l2_nxt    = l2_r;
    l3_nxt    = l3_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          cx_nxt    = in_item.coord_x;
          cy_nxt    = in_item.coord_y;
          cz_nxt    = in_item.coord_z;
          scale_nxt = SCALE_ONE;
          amp_nxt   = AMP_ONE;
          sum_nxt   = '0;
          oct_nxt   = '0;
          step_nxt  = ST_SX0;
          phase_nxt = 1'b0;
          if (int'(octave_count) > MAX_OCTAVES)
            n_nxt = OCT_CW'(MAX_OCTAVES);
          else
            n_nxt = OCT_CW'(octave_count);
          state_nxt = (octave_count == '0) ? S_FIN : S_RUN;
        end
      end
      S_RUN: begin
        if (is_mul && !phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          step_nxt  = step_r + 6'd1;
          case (step_r)
            ST_SX0, ST_SY0, ST_SZ0: tmp_nxt = mul_p[35:0];
            ST_SX1: sx_nxt = s36[35:12];
            ST_SY1: sy_nxt = s36[35:12];
            ST_SZ1: sz_nxt = s36[35:12];
            ST_HA:  a_nxt  = rom_q + cell_y;
            ST_HB:  b_nxt  = rom_q + cell_y;
            ST_HAA: aa_nxt = rom_q + cell_z;
            ST_HAB: ab_nxt = rom_q + cell_z;
            ST_HBA: ba_nxt = rom_q + cell_z;
            ST_HBB: bb_nxt = rom_q + cell_z;
            ST_G0:  hh_nxt[0] = rom_q[3:0];
            ST_G1:  hh_nxt[1] = rom_q[3:0];
            ST_G2:  hh_nxt[2] = rom_q[3:0];
            ST_G3:  hh_nxt[3] = rom_q[3:0];
            ST_G4:  hh_nxt[4] = rom_q[3:0];
            ST_G5:  hh_nxt[5] = rom_q[3:0];
            ST_G6:  hh_nxt[6] = rom_q[3:0];
            ST_G7:  hh_nxt[7] = rom_q[3:0];
            ST_FXA, ST_FYA, ST_FZA: inner_nxt = $signed(mul_p[2*F+4:F]) + TEN_ONE;
            ST_FXB, ST_FYB, ST_FZB: t2_nxt = mul_p[2*F-1:F];
            ST_FXC, ST_FYC, ST_FZC: t3_nxt = mul_p[2*F-1:F];
            ST_FXD: u_nxt = mul_p[2*F:F];
            ST_FYD: v_nxt = mul_p[2*F:F];
            ST_FZD: w_nxt = mul_p[2*F:F];
            ST_L0:  l0_nxt  = la + $signed(mul_p[F+V_W-1:F]);
            ST_L1:  l1_nxt  = la + $signed(mul_p[F+V_W-1:F]);
            ST_LO:  lo_nxt  = la + $signed(mul_p[F+V_W-1:F]);
            ST_L2:  l2_nxt  = la + $signed(mul_p[F+V_W-1:F]);
            ST_L3:  l3_nxt  = la + $signed(mul_p[F+V_W-1:F]);
            ST_HI:  hi_nxt  = la + $signed(mul_p[F+V_W-1:F]);
            ST_LR:  res_nxt = la + $signed(mul_p[F+V_W-1:F]);
            ST_ACC: sum_nxt = sum_r + $signed(mul_p[SUM_W-1:0]);
            ST_AMP: amp_nxt = $signed(mul_p[14+AMP_W-1:14]);
            ST_SC0: acc_nxt = ACC_W'(mul_p[31:0]);
            ST_SC1: acc_nxt = acc_r + (ACC_W'(mul_p[31:0]) << 16);
            ST_SC2: acc_nxt = acc_r + (ACC_W'(mul_p[31:0]) << 32);
            ST_CAP: begin
              // Clamp the running scale, then close the octave
              scale_nxt = (|acc_r[63:60]) ? SCALE_CAP : acc_r[59:12];
              step_nxt  = ST_SX0;
              if (OCT_CW'(oct_r + 1'b1) == n_r)
                state_nxt = S_FIN;
              else
                oct_nxt = oct_r + 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_FIN: begin
        if (ctl.fin_ack)
          state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= ST_SX0;
      phase_r <= 1'b0;
      oct_r   <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
      oct_r   <= oct_nxt;
      n_r     <= n_nxt;
    end
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    cz_r    <= cz_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    sz_r    <= sz_nxt;
    tmp_r   <= tmp_nxt;
    scale_r <= scale_nxt;
    acc_r   <= acc_nxt;
    amp_r   <= amp_nxt;
    sum_r   <= sum_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    aa_r    <= aa_nxt;
    ab_r    <= ab_nxt;
    ba_r    <= ba_nxt;
    bb_r    <= bb_nxt;
    hh_r    <= hh_nxt;
    inner_r <= inner_nxt;
    t2_r    <= t2_nxt;
    t3_r    <= t3_nxt;
    u_r     <= u_nxt;
    v_r     <= v_nxt;
    w_r     <= w_nxt;
    l0_r    <= l0_nxt;
    l1_r    <= l1_nxt;
    l2_r    <= l2_nxt;
    l3_r    <= l3_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    res_r   <= res_nxt;
  end

  // Fold the signed sum to a saturated magnitude
  assign sum_abs = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign q       = sum_abs[SUM_W-1:14];
  assign result.saturated        = |q[Q_W-1:TURB_W];
  assign result.turbulence_value = result.saturated ? '1 : q[TURB_W-1:0];

  assign stat.idle = (state_r == S_IDLE);
  assign stat.fin  = (state_r == S_FIN);

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> state_r == S_IDLE)
    else $error("item started while sequencer busy");

  a_rom_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && is_rom) |-> !phase_r)
    else $error("table step entered multiply phase");

  a_oct_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> oct_r < n_r)
    else $error("octave counter out of range");

  a_zero_oct: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.start && state_r == S_IDLE && octave_count == '0) |=> state_r == S_FIN)
    else $error("zero octaves did not finish at once");

endmodule
